### src/swst_pkg.sv
// Shared constants, types and slope tables for the sliding-window slope trend core.
package swst_pkg;

   localparam int WINDOW   = 16;
   localparam int SAMPLE_W = 32;
   localparam int SLOPE_W  = 32;
   localparam int HELD_W   = 5;
   localparam int TREND_W  = 2;
   localparam int Q_FRAC   = 16;

   localparam int PTR_W   = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SX_MAX  = WINDOW * (WINDOW - 1) / 2;
   localparam int SX_W    = $clog2(SX_MAX + 1);
   localparam int DEN_MAX = WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12;
   localparam int DEN_W   = $clog2(DEN_MAX + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
   localparam int SXY_W   = SAMPLE_W + SX_W;
   localparam int P1_W    = CNT_W + SXY_W;
   localparam int P2_W    = SX_W + SUM_W;
   localparam int NUM_W   = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
   localparam int UP_W    = SLOPE_W + DEN_W + 1;
   localparam int CMP_W   = ((NUM_W + Q_FRAC > UP_W) ? NUM_W + Q_FRAC : UP_W) + 1;

   localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(65536);

   typedef enum logic [TREND_W-1:0] {
      TREND_STEADY = 2'd0,
      TREND_UP     = 2'd1,
      TREND_DOWN   = 2'd2
   } trend_type;

   typedef logic [SX_W-1:0]  sx_table_type  [WINDOW+1];
   typedef logic [DEN_W-1:0] den_table_type [WINDOW+1];

   typedef struct packed {
      logic load;    // transfer accepted, start ring read
      logic update;  // write ring, update running sums
   } win_ctrl_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum_y;
      logic [SXY_W-1:0] sum_xy;
      logic [CNT_W-1:0] fill;
   } win_stat_type;

   // Sx = n(n-1)/2 for each fill count
   function automatic sx_table_type build_sx_table();
      sx_table_type t;
      for (int k = 0; k <= WINDOW; k++) begin
         t[k] = SX_W'(k * (k - 1) / 2);
      end
      return t;
   endfunction

   // n*Sxx - Sx^2 = n^2(n^2-1)/12
   function automatic den_table_type build_den_table();
      den_table_type t;
      for (int k = 0; k <= WINDOW; k++) begin
         t[k] = DEN_W'(k * k * (k * k - 1) / 12);
      end
      return t;
   endfunction

   localparam sx_table_type  SX_TABLE  = build_sx_table();
   localparam den_table_type DEN_TABLE = build_den_table();

endpackage

### src/swst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module swst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/swst_window.sv
// Sample ring in RAM with oldest pointer, fill count and running sums of y and x*y.
module swst_window (
   input  logic                          clock,
   input  logic                          reset,
   input  swst_pkg::win_ctrl_type        ctrl,
   input  logic [swst_pkg::SAMPLE_W-1:0] sample,
   output swst_pkg::win_stat_type        stat
);
   import swst_pkg::*;

   logic [SAMPLE_W-1:0] y_ff, y_in;
   logic [PTR_W-1:0]    oldest_ff, oldest_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_y_ff, sum_y_in;
   logic [SXY_W-1:0]    sum_xy_ff, sum_xy_in;

   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0] drop;
   logic [PTR_W-1:0]    wr_addr;
   logic [CNT_W:0]      wrap_sum;
   logic [CNT_W:0]      wrap_pos;
   logic [CNT_W-1:0]    weight;
   logic [SXY_W-1:0]    weighted;
   logic [SUM_W-1:0]    sum_less;
   logic                full;

   // Ring read is issued on the accepting edge; when the window is full the write to the same
   // entry follows in the next cycle, after the old sample has been captured.
   swst_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctrl.update),
      .wr_addr (wr_addr),
      .wr_data (y_ff),
      .rd_en   (ctrl.load),
      .rd_addr (oldest_ff),
      .rd_data (rd_data)
   );

   assign full     = (fill_ff == CNT_W'(WINDOW));
   assign wrap_sum = (CNT_W+1)'(oldest_ff) + (CNT_W+1)'(fill_ff);
   assign wrap_pos = (wrap_sum >= (CNT_W+1)'(WINDOW)) ? wrap_sum - (CNT_W+1)'(WINDOW)
                                                       : wrap_sum;
   assign wr_addr  = full ? oldest_ff : PTR_W'(wrap_pos);

   // new sample enters at x = n-1 of the window after the update
   assign weight   = full ? fill_ff - CNT_W'(1) : fill_ff;
   assign weighted = SXY_W'(weight) * SXY_W'(y_ff);
   assign drop     = full ? rd_data : '0;
   assign sum_less = sum_y_ff - SUM_W'(drop);

   always_comb begin
      y_in      = y_ff;
      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      sum_y_in  = sum_y_ff;
      sum_xy_in = sum_xy_ff;
      if (ctrl.load) begin
         y_in = sample;
      end
      if (ctrl.update) begin
         sum_y_in = sum_less + SUM_W'(y_ff);
         // full window: every remaining sample shifts down one x position
         sum_xy_in = sum_xy_ff - (full ? SXY_W'(sum_less) : '0) + weighted;
         if (full) begin
            oldest_in = (oldest_ff == PTR_W'(WINDOW - 1)) ? '0 : oldest_ff + PTR_W'(1);
         end else begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      if (reset) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
         sum_y_ff  <= '0;
         sum_xy_ff <= '0;
      end else begin
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
         sum_y_ff  <= sum_y_in;
         sum_xy_ff <= sum_xy_in;
      end
   end

   assign stat.sum_y  = sum_y_ff;
   assign stat.sum_xy = sum_xy_ff;
   assign stat.fill   = fill_ff;

endmodule

### src/swst_slope.sv
// Least-squares slope products and the threshold comparison that gives the trend.
module swst_slope (
   input  logic                                clock,
   input  logic                                mul,
   input  swst_pkg::win_stat_type              stat,
   input  logic signed [swst_pkg::SLOPE_W-1:0] min_slope,
   output swst_pkg::trend_type                 trend
);
   import swst_pkg::*;

   logic [P1_W-1:0]        p1_ff, p1_in;
   logic [P2_W-1:0]        p2_ff, p2_in;
   logic signed [UP_W-1:0] p3_ff, p3_in;
   logic                   few_ff, few_in;

   logic signed [DEN_W:0]   den_s;
   logic signed [NUM_W-1:0] num;
   logic signed [CMP_W-1:0] num_sh;
   logic signed [CMP_W-1:0] up;
   logic signed [CMP_W-1:0] neg_up;

   assign den_s = {1'b0, DEN_TABLE[stat.fill]};

   always_comb begin
      p1_in  = p1_ff;
      p2_in  = p2_ff;
      p3_in  = p3_ff;
      few_in = few_ff;
      if (mul) begin
         p1_in  = P1_W'(stat.fill) * P1_W'(stat.sum_xy);
         p2_in  = P2_W'(SX_TABLE[stat.fill]) * P2_W'(stat.sum_y);
         p3_in  = UP_W'(min_slope) * UP_W'(den_s);
         few_in = (stat.fill < CNT_W'(2));
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      p3_ff  <= p3_in;
      few_ff <= few_in;
   end

   // num * 2^16 against threshold * den, exact
   assign num    = $signed(NUM_W'(p1_ff)) - $signed(NUM_W'(p2_ff));
   assign num_sh = CMP_W'(num) <<< Q_FRAC;
   assign up     = CMP_W'(p3_ff);
   assign neg_up = -up;

   always_comb begin
      if (few_ff) begin
         trend = TREND_STEADY;
      end else if (num_sh >= up) begin
         trend = TREND_UP;      // wins when a negative threshold lets both hold
      end else if (num_sh <= neg_up) begin
         trend = TREND_DOWN;
      end else begin
         trend = TREND_STEADY;
      end
   end

endmodule

### src/sliding_window_slope_trend_core.sv
// Sliding-window least-squares slope trend core: top level, sequencer and result register.
// Result path: after the input transfer come the ring read, the sum update and the products, then the result register.
// Samples are not overlapped: req_stall holds off the next sample until the previous result is loaded.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active high) empties the window, zeroes the sums and sets min_slope to 1.0.
// The ring RAM is not cleared; an entry's read data is only used after it has been written.
module sliding_window_slope_trend_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swst_pkg::SAMPLE_W-1:0] req_sample_kb,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [swst_pkg::TREND_W-1:0]  rsp_trend,
   output logic [swst_pkg::HELD_W-1:0]   rsp_samples_held,
   input  logic                          csr_wr_en,
   input  logic [swst_pkg::SLOPE_W-1:0]  csr_wr_data
);
   import swst_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_CMP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TREND_W-1:0]   rsp_trend_ff, rsp_trend_in;
   logic [HELD_W-1:0]    rsp_held_ff, rsp_held_in;
   logic [SLOPE_W-1:0]   min_slope_ff, min_slope_in;

   win_ctrl_type         win_ctrl;
   win_stat_type         win_stat;
   logic                 mul;
   logic                 rsp_load;
   trend_type            trend;

   swst_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (win_ctrl),
      .sample (req_sample_kb),
      .stat   (win_stat)
   );

   swst_slope u_slope (
      .clock     (clock),
      .mul       (mul),
      .stat      (win_stat),
      .min_slope ($signed(min_slope_ff)),
      .trend     (trend)
   );

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      win_ctrl.load   = 1'b0;
      win_ctrl.update = 1'b0;
      mul             = 1'b0;
      rsp_load        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               win_ctrl.load = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            win_ctrl.update = 1'b1;
            state_in        = ST_MUL;
         end
         ST_MUL: begin
            mul      = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_trend_in = rsp_trend_ff;
      rsp_held_in  = rsp_held_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_trend_in = trend;
         // samples_held wraps modulo 32 for windows beyond 31
         rsp_held_in  = HELD_W'(win_stat.fill);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign min_slope_in = csr_wr_en ? csr_wr_data : min_slope_ff;

   always_ff @(posedge clock) begin
      rsp_trend_ff <= rsp_trend_in;
      rsp_held_ff  <= rsp_held_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_slope_ff <= SLOPE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_slope_ff <= min_slope_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_trend        = rsp_trend_ff;
   assign rsp_samples_held = rsp_held_ff;

   a_accept_reaches_cmp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##3 (state_ff == ST_CMP))
      else $error("accepted sample did not reach the compare stage");

   a_cmp_loads_empty_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into empty output register");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (win_stat.fill <= CNT_W'(WINDOW)))
      else $error("window fill count exceeds window size");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sliding-window slope trend core, with its trend scoreboard.
module tb_top;
   import swst_pkg::*;

   typedef struct packed {
      trend_type         trend;
      logic [HELD_W-1:0] held;
   } trend_result_type;

   class trend_scoreboard;
      logic [SAMPLE_W-1:0] ring [WINDOW];
      int unsigned         oldest;
      int unsigned         fill;
      longint unsigned     sum_y;
      longint unsigned     sum_xy;
      longint              threshold;
      trend_result_type    expected_trends [$];
      int                  errors;

      function new();
         oldest    = 0;
         fill      = 0;
         sum_y     = 0;
         sum_xy    = 0;
         threshold = 65536;
         errors    = 0;
      endfunction

      function void set_threshold(logic [SLOPE_W-1:0] v);
         threshold = longint'($signed(v));
      endfunction

      // window update and least-squares slope test for one accepted sample
      function void note_sample(logic [SAMPLE_W-1:0] y);
         int unsigned      pos;
         longint           n, sx, sxx, den, num, up;
         trend_result_type res;
         if (fill < WINDOW) begin
            pos = (oldest + fill) % WINDOW;
            ring[pos] = y;
            sum_xy += longint'(fill) * longint'({32'd0, y});
            sum_y  += {32'd0, y};
            fill++;
         end else begin
            pos = oldest;
            sum_y  -= {32'd0, ring[pos]};
            sum_xy -= sum_y;   // every sample moves down one x position
            ring[pos] = y;
            sum_xy += longint'(WINDOW - 1) * longint'({32'd0, y});
            sum_y  += {32'd0, y};
            oldest = (pos + 1) % WINDOW;
         end
         res.trend = TREND_STEADY;
         res.held  = fill[HELD_W-1:0];
         if (fill >= 2) begin
            n   = fill;
            sx  = n * (n - 1) / 2;
            sxx = (n - 1) * n * (2 * n - 1) / 6;
            den = n * sxx - sx * sx;
            num = n * longint'(sum_xy) - sx * longint'(sum_y);
            up  = threshold * den;
            // arithmetic shift gives the floor; ceiling via negation
            if (num >= -((-up) >>> Q_FRAC))
               res.trend = TREND_UP;
            else if (num <= ((-up) >>> Q_FRAC))
               res.trend = TREND_DOWN;
         end
         expected_trends.insert(expected_trends.size(), res);
      endfunction

      function void check_result(logic [TREND_W-1:0] trend, logic [HELD_W-1:0] held);
         trend_result_type exp_res;
         if (expected_trends.size() == 0) begin
            $display("%0t: unexpected result trend=%0d held=%0d", $time, trend, held);
            errors++;
         end else begin
            exp_res = expected_trends.pop_front();
            if (trend !== exp_res.trend) begin
               $display("%0t: trend mismatch expected=%0d actual=%0d",
                        $time, exp_res.trend, trend);
               errors++;
            end
            if (held !== exp_res.held) begin
               $display("%0t: samples_held mismatch expected=%0d actual=%0d",
                        $time, exp_res.held, held);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_kb;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [TREND_W-1:0]  rsp_trend;
   logic [HELD_W-1:0]   rsp_samples_held;
   logic                csr_wr_en;
   logic [SLOPE_W-1:0]  csr_wr_data;
   bit                  quiet;

   trend_scoreboard sb = new();

   sliding_window_slope_trend_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_kb    (req_sample_kb),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_trend        (rsp_trend),
      .rsp_samples_held (rsp_samples_held),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb_top NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_sample(req_sample_kb);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_trend, rsp_samples_held);
   end

   // receiver back-pressure: short bursts mostly, the odd long one
   initial begin
      int go_len, hold_len;
      rsp_stall = 1'b0;
      forever begin
         go_len = $urandom_range(0, 6);
         repeat (go_len) @(negedge clock) rsp_stall <= 1'b0;
         hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
         repeat (hold_len) @(negedge clock) rsp_stall <= !quiet;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] y);
      int gap;
      if (quiet)
         gap = 0;
      else if ($urandom_range(0, 11) == 0)
         gap = $urandom_range(10, 50);
      else
         gap = $urandom_range(0, 2);
      if (gap > 0 && req_valid) begin
         @(negedge clock) req_valid <= 1'b0;
         gap--;
      end
      repeat (gap) @(negedge clock);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_kb <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every expected result has been seen
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.expected_trends.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [SLOPE_W-1:0] v);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock) csr_wr_en <= 1'b0;
      sb.set_threshold(v);
   endtask

   task automatic run_phase(input logic [SLOPE_W-1:0] thr, input int count);
      int     sent, len, kind, noise;
      longint k, base, y;
      write_threshold(thr);
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 19);
         len  = $urandom_range(16, 24);
         if (kind < 14) begin
            // ramp whose slope sits near the threshold or near its negation
            k = ($signed(thr) >>> Q_FRAC) + longint'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 2) == 0)
               k = -k;
            base  = longint'($urandom_range(32'h0010_0000, 32'hFFF0_0000));
            noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
         end
         for (int i = 0; i < len && sent < count; i++) begin
            if (kind < 14) begin
               y = base + k * i + longint'($urandom_range(0, noise));
               if (y < 0)
                  y = 0;
               else if (y > 64'hFFFF_FFFF)
                  y = 64'hFFFF_FFFF;
            end else if (kind < 17) begin
               y = longint'($urandom());
            end else if (kind < 19) begin
               y = (kind == 17) ? 0 : 64'hFFFF_FFFF;
            end else begin
               y = ($urandom_range(0, 1) == 0) ? 0 : 64'hFFFF_FFFF;
            end
            send_sample(y[SAMPLE_W-1:0]);
            sent++;
         end
      end
   endtask

   initial begin
      logic [SLOPE_W-1:0] thr_list [14];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_kb = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      quiet         = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: reset threshold of 1.0, extremes, window fill and wrap
      send_sample(32'd0);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'd0);
      for (int i = 0; i < 18; i++)
         send_sample(32'd100 + i);
      // negative threshold, then two repeated samples at the end of a rising window
      write_threshold(32'hFFFF_FFFF);
      send_sample(32'd117);
      send_sample(32'd117);

      thr_list[0] = 32'h0000_0000;
      thr_list[1] = 32'h0000_0001;
      thr_list[2] = 32'hFFFF_FFFF;
      thr_list[3] = 32'h7FFF_FFFF;
      thr_list[4] = 32'h8000_0000;
      thr_list[5] = 32'h0002_0000;
      thr_list[6] = 32'hFFFE_0000;
      for (int p = 7; p < 14; p++) begin
         if (p % 2 == 0)
            thr_list[p] = $urandom();
         else
            thr_list[p] = {16'($signed($urandom_range(0, 128)) - 16'sd64), 16'd0};
      end
      for (int p = 0; p < 14; p++) begin
         quiet = (p == 3 || p == 9);
         run_phase(thr_list[p], 125);
      end
      quiet = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule

### files.f
src/swst_pkg.sv
src/swst_ram.sv
src/swst_window.sv
src/swst_slope.sv
src/sliding_window_slope_trend_core.sv
tb/tb_top.sv
